// ===== hw/rtl/smgm_pkg.sv =====
package smgm_pkg;

    localparam logic [1:0] OP_GAIN   = 2'd0;
    localparam logic [1:0] OP_ROUTE  = 2'd1;
    localparam logic [1:0] OP_BLOCK  = 2'd2;
    localparam logic [1:0] OP_SAMPLE = 2'd3;

    localparam int COEF_BASE  = 45875;
    localparam int COEF_SPAN  = 19005;
    localparam logic [16:0] SMOOTH_MAX = 17'd65536;
    localparam logic [16:0] GAIN_MAX   = 17'd131071;

    localparam logic signed [30:0] ACC_MAX = 31'sd536870911;
    localparam logic signed [30:0] ACC_MIN = -31'sd536870912;
    localparam logic signed [29:0] OUT_MAX = 30'sd8388607;
    localparam logic signed [29:0] OUT_MIN = -30'sd8388608;

    typedef struct packed {
        logic capture;
        logic clr_step;
        logic load_gain;
        logic set_route;
        logic coef;
        logic b_read;
        logic b_mul;
        logic b_write;
        logic b_skip;
        logic p_read;
        logic p_mul;
        logic p_acc;
        logic d_acc;
        logic emit;
    } t_cmd;

    typedef struct packed {
        logic       clr_last;
        logic       o_last;
        logic       s_last;
        logic       route_zero;
        logic       src_ok;
        logic       spk_ok;
        logic       direct_ok;
        logic       last_src;
        logic       out_busy;
        logic [1:0] op;
    } t_sts;

endpackage

// ===== hw/rtl/smgm_ram.sv =====
module smgm_ram #(
    parameter int WIDTH = 17,
    parameter int DEPTH = 256,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== hw/rtl/smgm_ctrl.sv =====
module smgm_ctrl (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_valid,
    output logic            o_stall,
    input  smgm_pkg::t_sts  i_sts,
    output smgm_pkg::t_cmd  o_cmd
);
    import smgm_pkg::*;

    typedef enum logic [12:0] {
        S_CLEAR = 13'b0000000000001,
        S_IDLE  = 13'b0000000000010,
        S_DISP  = 13'b0000000000100,
        S_COEF  = 13'b0000000001000,
        S_BCHK  = 13'b0000000010000,
        S_BRD   = 13'b0000000100000,
        S_BMUL  = 13'b0000001000000,
        S_BWR   = 13'b0000010000000,
        S_PRD   = 13'b0000100000000,
        S_PMUL  = 13'b0001000000000,
        S_PACC  = 13'b0010000000000,
        S_DIR   = 13'b0100000000000,
        S_EMIT  = 13'b1000000000000
    } t_state;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            S_CLEAR: begin
                o_cmd.clr_step = 1'b1;
                if (i_sts.clr_last) n_state = S_IDLE;
            end
            S_IDLE: begin
                if (i_valid) begin
                    o_cmd.capture = 1'b1;
                    n_state = S_DISP;
                end
            end
            S_DISP: begin
                unique case (i_sts.op)
                    OP_GAIN: begin
                        o_cmd.load_gain = i_sts.src_ok & i_sts.spk_ok;
                        n_state = S_IDLE;
                    end
                    OP_ROUTE: begin
                        o_cmd.set_route = i_sts.src_ok;
                        n_state = S_IDLE;
                    end
                    OP_BLOCK: begin
                        n_state = S_COEF;
                    end
                    OP_SAMPLE: begin
                        if (i_sts.src_ok && i_sts.route_zero) n_state = S_PRD;
                        else if (i_sts.src_ok && i_sts.direct_ok) n_state = S_DIR;
                        else if (i_sts.last_src) n_state = S_EMIT;
                        else n_state = S_IDLE;
                    end
                    default: n_state = S_IDLE;
                endcase
            end
            S_COEF: begin
                o_cmd.coef = 1'b1;
                n_state = S_BCHK;
            end
            S_BCHK: begin
                if (i_sts.route_zero) begin
                    n_state = S_BRD;
                end else begin
                    o_cmd.b_skip = 1'b1;
                    if (i_sts.s_last) n_state = S_IDLE;
                end
            end
            S_BRD: begin
                o_cmd.b_read = 1'b1;
                n_state = S_BMUL;
            end
            S_BMUL: begin
                o_cmd.b_mul = 1'b1;
                n_state = S_BWR;
            end
            S_BWR: begin
                o_cmd.b_write = 1'b1;
                if (!i_sts.o_last) n_state = S_BRD;
                else if (i_sts.s_last) n_state = S_IDLE;
                else n_state = S_BCHK;
            end
            S_PRD: begin
                o_cmd.p_read = 1'b1;
                n_state = S_PMUL;
            end
            S_PMUL: begin
                o_cmd.p_mul = 1'b1;
                n_state = S_PACC;
            end
            S_PACC: begin
                o_cmd.p_acc = 1'b1;
                if (!i_sts.o_last) n_state = S_PRD;
                else if (i_sts.last_src) n_state = S_EMIT;
                else n_state = S_IDLE;
            end
            S_DIR: begin
                o_cmd.d_acc = 1'b1;
                n_state = i_sts.last_src ? S_EMIT : S_IDLE;
            end
            S_EMIT: begin
                if (!i_sts.out_busy) begin
                    o_cmd.emit = 1'b1;
                    if (i_sts.o_last) n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    assign o_stall = (r_state != S_IDLE);

endmodule

// ===== hw/rtl/smgm_datapath.sv =====
module smgm_datapath #(
    parameter int NUM_SOURCES  = 16,
    parameter int NUM_SPEAKERS = 16
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  smgm_pkg::t_cmd      i_cmd,
    output smgm_pkg::t_sts      o_sts,
    input  logic [1:0]          i_op,
    input  logic [3:0]          i_source,
    input  logic [3:0]          i_speaker,
    input  logic [16:0]         i_gain,
    input  logic [4:0]          i_route,
    input  logic signed [23:0]  i_sample,
    input  logic                i_last_source,
    input  logic [16:0]         i_smoothing,
    input  logic [4:0]          i_active_outputs,
    input  logic                i_stall,
    output logic                o_valid,
    output logic [3:0]          o_speaker_index,
    output logic signed [23:0]  o_mixed_sample,
    output logic                o_last
);
    import smgm_pkg::*;

    localparam int DEPTH = NUM_SOURCES * NUM_SPEAKERS;
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int SCW   = (NUM_SOURCES > 1) ? $clog2(NUM_SOURCES) : 1;
    localparam int OW    = (NUM_SPEAKERS > 1) ? $clog2(NUM_SPEAKERS) : 1;
    localparam int NW    = $clog2(NUM_SPEAKERS + 1);
    localparam logic [AW-1:0] NSP_A = AW'(NUM_SPEAKERS);

    logic [1:0]         r_op;
    logic [3:0]         r_src;
    logic [3:0]         r_spk;
    logic [16:0]        r_gain;
    logic [4:0]         r_route;
    logic signed [23:0] r_sample;
    logic               r_last_src;

    logic [AW-1:0]      r_clr_cnt;
    logic [SCW-1:0]     r_s_cnt;
    logic [OW-1:0]      r_o_cnt;
    logic [15:0]        r_coef;
    logic signed [34:0] r_bprod;
    logic [16:0]        r_g;
    logic signed [41:0] r_pprod;

    logic [4:0]         r_route_tab [NUM_SOURCES];
    logic signed [29:0] r_acc [NUM_SPEAKERS];

    logic               r_out_valid;
    logic [3:0]         r_out_idx;
    logic signed [23:0] r_out_data;
    logic               r_out_last;

    logic [NW-1:0]      w_n;
    logic [SCW-1:0]     w_src_idx;
    logic [SCW-1:0]     w_rt_idx;
    logic [4:0]         w_rt;
    logic               w_o_last;
    logic [AW-1:0]      w_pair_blk;
    logic [AW-1:0]      w_pair_smp;
    logic [AW-1:0]      w_pair_load;
    logic [16:0]        w_tg;
    logic [16:0]        w_sg;
    logic [16:0]        w_sm;
    logic [31:0]        w_cprod;
    logic signed [17:0] w_d;
    logic signed [34:0] w_bsum;
    logic signed [18:0] w_bround;
    logic signed [19:0] w_y;
    logic [16:0]        w_ynew;
    logic signed [41:0] w_psum;
    logic signed [25:0] w_pround;
    logic signed [25:0] w_addend;
    logic [OW-1:0]      w_acc_idx;
    logic signed [29:0] w_acc_cur;
    logic signed [30:0] w_accsum;
    logic signed [29:0] w_accsat;
    logic signed [23:0] w_outsat;
    logic               w_t_we;
    logic [AW-1:0]      w_t_waddr;
    logic [16:0]        w_t_wdata;
    logic               w_s_we;
    logic [AW-1:0]      w_s_waddr;
    logic [16:0]        w_s_wdata;
    logic [AW-1:0]      w_s_raddr;

    always_comb begin
        if (i_active_outputs == 5'd0) w_n = NW'(1);
        else if (int'(i_active_outputs) > NUM_SPEAKERS) w_n = NW'(NUM_SPEAKERS);
        else w_n = NW'(i_active_outputs);
    end

    assign w_src_idx   = SCW'(r_src);
    assign w_rt_idx    = (r_op == OP_BLOCK) ? r_s_cnt : w_src_idx;
    assign w_rt        = r_route_tab[w_rt_idx];
    assign w_o_last    = ((NW'(r_o_cnt) + NW'(1)) == w_n);
    assign w_pair_blk  = AW'(r_s_cnt) * NSP_A + AW'(r_o_cnt);
    assign w_pair_smp  = AW'(w_src_idx) * NSP_A + AW'(r_o_cnt);
    assign w_pair_load = AW'(w_src_idx) * NSP_A + AW'(OW'(r_spk));

    assign o_sts.clr_last   = (r_clr_cnt == AW'(DEPTH - 1));
    assign o_sts.o_last     = w_o_last;
    assign o_sts.s_last     = (r_s_cnt == SCW'(NUM_SOURCES - 1));
    assign o_sts.route_zero = (w_rt == 5'd0);
    assign o_sts.src_ok     = (int'(r_src) < NUM_SOURCES);
    assign o_sts.spk_ok     = (int'(r_spk) < NUM_SPEAKERS);
    assign o_sts.direct_ok  = (w_rt != 5'd0) && (int'(w_rt) <= int'(w_n));
    assign o_sts.last_src   = r_last_src;
    assign o_sts.out_busy   = r_out_valid & i_stall;
    assign o_sts.op         = r_op;

    assign w_t_we    = i_cmd.clr_step | i_cmd.load_gain;
    assign w_t_waddr = i_cmd.clr_step ? r_clr_cnt : w_pair_load;
    assign w_t_wdata = i_cmd.clr_step ? 17'd0 : r_gain;
    assign w_s_we    = i_cmd.clr_step | i_cmd.b_write;
    assign w_s_waddr = i_cmd.clr_step ? r_clr_cnt : w_pair_blk;
    assign w_s_wdata = i_cmd.clr_step ? 17'd0 : w_ynew;
    assign w_s_raddr = (r_op == OP_BLOCK) ? w_pair_blk : w_pair_smp;

    smgm_ram #(.WIDTH(17), .DEPTH(DEPTH)) u_target_ram (
        .i_clk   (i_clk),
        .i_we    (w_t_we),
        .i_waddr (w_t_waddr),
        .i_wdata (w_t_wdata),
        .i_raddr (w_pair_blk),
        .o_rdata (w_tg)
    );

    smgm_ram #(.WIDTH(17), .DEPTH(DEPTH)) u_smooth_ram (
        .i_clk   (i_clk),
        .i_we    (w_s_we),
        .i_waddr (w_s_waddr),
        .i_wdata (w_s_wdata),
        .i_raddr (w_s_raddr),
        .o_rdata (w_sg)
    );

    assign w_sm    = (i_smoothing > SMOOTH_MAX) ? SMOOTH_MAX : i_smoothing;
    assign w_cprod = {15'd0, w_sm} * 32'(COEF_SPAN) + 32'd32768;

    assign w_d      = $signed({1'b0, w_sg}) - $signed({1'b0, w_tg});
    assign w_bsum   = r_bprod + 35'sd32768;
    assign w_bround = w_bsum[34:16];
    assign w_y      = $signed({3'b000, r_g}) + $signed({w_bround[18], w_bround});

    always_comb begin
        if (w_y <= 20'sd0) w_ynew = 17'd0;
        else if (w_y > $signed({3'b000, GAIN_MAX})) w_ynew = GAIN_MAX;
        else w_ynew = w_y[16:0];
    end

    assign w_psum    = r_pprod + 42'sd32768;
    assign w_pround  = w_psum[41:16];
    assign w_addend  = i_cmd.d_acc ? 26'(r_sample) : w_pround;
    assign w_acc_idx = i_cmd.d_acc ? OW'(w_rt - 5'd1) : r_o_cnt;
    assign w_acc_cur = r_acc[w_acc_idx];
    assign w_accsum  = 31'(w_acc_cur) + 31'(w_addend);

    always_comb begin
        if (w_accsum > ACC_MAX) w_accsat = 30'(ACC_MAX);
        else if (w_accsum < ACC_MIN) w_accsat = 30'(ACC_MIN);
        else w_accsat = w_accsum[29:0];
        if (w_acc_cur > OUT_MAX) w_outsat = 24'(OUT_MAX);
        else if (w_acc_cur < OUT_MIN) w_outsat = 24'(OUT_MIN);
        else w_outsat = w_acc_cur[23:0];
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_op       <= i_op;
            r_src      <= i_source;
            r_spk      <= i_speaker;
            r_gain     <= i_gain;
            r_route    <= i_route;
            r_sample   <= i_sample;
            r_last_src <= i_last_source;
        end
        if (i_cmd.coef) begin
            r_coef <= 16'(32'(COEF_BASE) + (w_cprod >> 16));
        end
        if (i_cmd.b_mul) begin
            r_bprod <= w_d * $signed({1'b0, r_coef});
            r_g     <= w_tg;
        end
        if (i_cmd.p_mul) begin
            r_pprod <= r_sample * $signed({1'b0, w_sg});
        end
        if (i_cmd.emit) begin
            r_out_idx  <= 4'(r_o_cnt);
            r_out_data <= w_outsat;
            r_out_last <= w_o_last;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_cnt   <= '0;
            r_s_cnt     <= '0;
            r_o_cnt     <= '0;
            r_out_valid <= 1'b0;
            for (int i = 0; i < NUM_SOURCES; i++) r_route_tab[i] <= 5'd0;
            for (int i = 0; i < NUM_SPEAKERS; i++) r_acc[i] <= 30'sd0;
        end else begin
            if (i_cmd.clr_step) r_clr_cnt <= r_clr_cnt + AW'(1);
            if (i_cmd.capture) begin
                r_s_cnt <= '0;
                r_o_cnt <= '0;
            end
            if (i_cmd.set_route) r_route_tab[w_src_idx] <= r_route;
            if (i_cmd.b_skip) begin
                r_s_cnt <= r_s_cnt + SCW'(1);
                r_o_cnt <= '0;
            end
            if (i_cmd.b_write) begin
                if (w_o_last) begin
                    r_o_cnt <= '0;
                    r_s_cnt <= r_s_cnt + SCW'(1);
                end else begin
                    r_o_cnt <= r_o_cnt + OW'(1);
                end
            end
            if (i_cmd.p_acc || i_cmd.emit) begin
                r_o_cnt <= w_o_last ? '0 : r_o_cnt + OW'(1);
            end
            if (i_cmd.p_acc || i_cmd.d_acc) r_acc[w_acc_idx] <= w_accsat;
            if (i_cmd.emit) r_acc[r_o_cnt] <= 30'sd0;
            if (i_cmd.emit) r_out_valid <= 1'b1;
            else if (!i_stall) r_out_valid <= 1'b0;
        end
    end

    assign o_valid         = r_out_valid;
    assign o_speaker_index = r_out_idx;
    assign o_mixed_sample  = r_out_data;
    assign o_last          = r_out_last;

endmodule

// ===== hw/rtl/smoothed_gain_matrix_mixer.sv =====
// Source-to-speaker gain matrix mixer with first-order gain smoothing.
// Input channel (i_valid / o_stall): one transaction carries an op code with
// its fields. A block boundary smooths every pair (n per panned source,
// n = active speakers) one at a time, as the gain memories have single read
// ports, and skips routed sources. A sample is accumulated into n speakers
// when panned or one when direct; a frame-ending sample then emits n results,
// one per cycle while i_stall does not hold the output register.
// Output channel (o_valid / i_stall): one transaction per speaker result,
// held in an output register while i_stall is high; emission waits on it.
// Configuration: APB writes to smoothing (0x0) and active_outputs (0x4).
// Reset: synchronous, active low. Routes and accumulators clear at once;
// the two gain memories are then zeroed, NUM_SOURCES * NUM_SPEAKERS entries
// (256 by default) one at a time, while o_stall stays high.
module smoothed_gain_matrix_mixer #(
    parameter int NUM_SOURCES  = 16,
    parameter int NUM_SPEAKERS = 16
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_stall,
    input  logic [1:0]         i_op,
    input  logic [3:0]         i_source,
    input  logic [3:0]         i_speaker,
    input  logic [16:0]        i_gain,
    input  logic [4:0]         i_route,
    input  logic signed [23:0] i_sample,
    input  logic               i_last_source,
    output logic               o_valid,
    input  logic               i_stall,
    output logic [3:0]         o_speaker_index,
    output logic signed [23:0] o_mixed_sample,
    output logic               o_last,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [2:0]         paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready
);
    import smgm_pkg::*;

    localparam logic REG_SMOOTHING = 1'b0;
    localparam logic REG_ACTIVE    = 1'b1;

    logic [16:0] r_smoothing;
    logic [4:0]  r_active;
    logic        w_wr;
    t_cmd        w_cmd;
    t_sts        w_sts;

    assign pready = 1'b1;
    assign w_wr   = psel & penable & pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_smoothing <= 17'd52429;
            r_active    <= 5'd16;
        end else if (w_wr) begin
            unique case (paddr[2])
                REG_SMOOTHING: r_smoothing <= pwdata[16:0];
                REG_ACTIVE:    r_active    <= pwdata[4:0];
                default:       r_active    <= r_active;
            endcase
        end
    end

    always_comb begin
        unique case (paddr[2])
            REG_SMOOTHING: prdata = {15'd0, r_smoothing};
            REG_ACTIVE:    prdata = {27'd0, r_active};
            default:       prdata = 32'd0;
        endcase
    end

    smgm_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_stall (o_stall),
        .i_sts   (w_sts),
        .o_cmd   (w_cmd)
    );

    smgm_datapath #(
        .NUM_SOURCES  (NUM_SOURCES),
        .NUM_SPEAKERS (NUM_SPEAKERS)
    ) u_datapath (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cmd            (w_cmd),
        .o_sts            (w_sts),
        .i_op             (i_op),
        .i_source         (i_source),
        .i_speaker        (i_speaker),
        .i_gain           (i_gain),
        .i_route          (i_route),
        .i_sample         (i_sample),
        .i_last_source    (i_last_source),
        .i_smoothing      (r_smoothing),
        .i_active_outputs (r_active),
        .i_stall          (i_stall),
        .o_valid          (o_valid),
        .o_speaker_index  (o_speaker_index),
        .o_mixed_sample   (o_mixed_sample),
        .o_last           (o_last)
    );

    a_last_ends_frame: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_last && !i_stall |=> !o_valid)
        else $error("result after end of frame");

    a_emit_while_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_valid) |-> $past(o_stall))
        else $error("result emitted while idle");

    a_frame_holds_input: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_last |-> o_stall)
        else $error("input taken inside an open frame");

endmodule

// ===== test/tb.sv =====
module tb;
    timeunit 1ns;
    timeprecision 1ps;
    import smgm_pkg::*;

    localparam int NSRC = 16;
    localparam int NSPK = 16;

    typedef struct {
        logic [3:0]  spk;
        logic [23:0] smp;
        logic        lst;
    } mix_result_t;

    class mix_scoreboard;
        logic [16:0] smoothing_reg;
        logic [4:0]  active_reg;
        logic [16:0] target_gain [NSRC*NSPK];
        logic [16:0] smoothed_gain [NSRC*NSPK];
        logic [4:0]  route_tbl [NSRC];
        longint      accum [NSPK];
        mix_result_t pending [$];
        int          errors;

        function void clear();
            smoothing_reg = 17'd52429;
            active_reg = 5'd16;
            foreach (target_gain[k]) begin
                target_gain[k] = '0;
                smoothed_gain[k] = '0;
            end
            foreach (route_tbl[k]) route_tbl[k] = '0;
            foreach (accum[k]) accum[k] = 0;
            pending.delete();
            errors = 0;
        endfunction

        function longint rnd16(longint p);
            longint t;
            t = p + 32768;
            if (t >= 0) return t / 65536;
            return -((-t + 65535) / 65536);
        endfunction

        function longint clampv(longint v, longint lo, longint hi);
            return v < lo ? lo : (v > hi ? hi : v);
        endfunction

        function void note_input(logic [1:0] op, logic [3:0] src, logic [3:0] spk,
                                 logic [16:0] gain, logic [4:0] route,
                                 logic signed [23:0] smp, logic lsrc);
            int n;
            longint c, g, d, sm, v;
            mix_result_t r;
            n = active_reg == 0 ? 1 : (active_reg > NSPK ? NSPK : active_reg);
            case (op)
                OP_GAIN: target_gain[src*NSPK+spk] = gain;
                OP_ROUTE: route_tbl[src] = route;
                OP_BLOCK: begin
                    sm = smoothing_reg > 65536 ? 65536 : smoothing_reg;
                    c = COEF_BASE + ((sm * COEF_SPAN + 32768) / 65536);
                    for (int s = 0; s < NSRC; s++) begin
                        if (route_tbl[s] != 0) continue;
                        for (int o = 0; o < n; o++) begin
                            g = target_gain[s*NSPK+o];
                            d = longint'(smoothed_gain[s*NSPK+o]) - g;
                            smoothed_gain[s*NSPK+o] = clampv(g + rnd16(d * c), 0, 131071);
                        end
                    end
                end
                default: begin
                    if (route_tbl[src] == 0) begin
                        for (int o = 0; o < n; o++)
                            accum[o] = clampv(accum[o] + rnd16(longint'(smp)
                                * longint'(smoothed_gain[src*NSPK+o])),
                                -536870912, 536870911);
                    end else if (route_tbl[src] - 1 < n) begin
                        accum[route_tbl[src]-1] = clampv(accum[route_tbl[src]-1]
                            + longint'(smp), -536870912, 536870911);
                    end
                    if (lsrc) begin
                        for (int o = 0; o < n; o++) begin
                            v = clampv(accum[o], -8388608, 8388607);
                            r.spk = 4'(o);
                            r.smp = v[23:0];
                            r.lst = (o + 1 == n);
                            pending = {pending, r};
                            accum[o] = 0;
                        end
                    end
                end
            endcase
        endfunction

        function void check_result(logic [3:0] spk, logic [23:0] smp, logic lst);
            mix_result_t e;
            if (pending.size() == 0) begin
                $display("%0t: unexpected result spk=%0d smp=%0d", $time, spk,
                         $signed(smp));
                errors++;
                return;
            end
            e = pending.pop_front();
            if (e.spk !== spk) begin
                $display("%0t: speaker expected %0d actual %0d", $time, e.spk, spk);
                errors++;
            end
            if (e.smp !== smp) begin
                $display("%0t: sample expected %0d actual %0d", $time,
                         $signed(e.smp), $signed(smp));
                errors++;
            end
            if (e.lst !== lst) begin
                $display("%0t: last expected %0b actual %0b", $time, e.lst, lst);
                errors++;
            end
        endfunction
    endclass

    logic i_clk = 0, i_rst_n = 0;
    logic i_valid = 0, i_stall = 0;
    logic o_stall, o_valid, o_last, pready;
    logic [1:0] i_op = '0;
    logic [3:0] i_source = '0, i_speaker = '0, o_speaker_index;
    logic [16:0] i_gain = '0;
    logic [4:0] i_route = '0;
    logic signed [23:0] i_sample = '0, o_mixed_sample;
    logic i_last_source = 0;
    logic psel = 0, penable = 0, pwrite = 0;
    logic [2:0] paddr = '0;
    logic [31:0] pwdata = '0, prdata;
    mix_scoreboard mix;
    bit rx_random = 0;

    always #4 i_clk = ~i_clk;

    smoothed_gain_matrix_mixer DUT (.*);

    task automatic apb_write(logic [2:0] addr, logic [31:0] data);
        psel <= 1; penable <= 0; pwrite <= 1; paddr <= addr; pwdata <= data;
        @(posedge i_clk);
        penable <= 1;
        @(posedge i_clk);
        psel <= 0; penable <= 0; pwrite <= 0;
        if (addr == 3'd0) mix.smoothing_reg = data[16:0];
        else mix.active_reg = data[4:0];
        @(posedge i_clk);
    endtask

    task automatic send_item(logic [1:0] op, logic [3:0] src, logic [3:0] spk,
                             logic [16:0] gain, logic [4:0] route,
                             logic [23:0] smp, logic lsrc, int gap);
        if (gap > 0) begin
            i_valid <= 0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid <= 1; i_op <= op; i_source <= src; i_speaker <= spk; i_gain <= gain;
        i_route <= route; i_sample <= smp; i_last_source <= lsrc;
        do @(posedge i_clk); while (o_stall);
        mix.note_input(op, src, spk, gain, route, smp, lsrc);
    endtask

    task automatic drain();
        i_valid <= 0;
        while (mix.pending.size() != 0) @(posedge i_clk);
        repeat (1200) @(posedge i_clk);
    endtask

    function automatic logic [23:0] rand_sample();
        case ($urandom_range(0, 3))
            0: return 24'h7FFFFF;
            1: return 24'h800000;
            default: return $urandom;
        endcase
    endfunction

    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && !i_stall)
            mix.check_result(o_speaker_index, o_mixed_sample, o_last);
    end

    int stall_left = 0;
    always @(posedge i_clk) begin
        if (!rx_random || ($urandom_range(0, 3) == 0 && stall_left == 0)) begin
            i_stall <= 0;
            stall_left <= rx_random ? $urandom_range(0, 9) : 0;
        end else if (stall_left > 0) begin
            i_stall <= 1;
            stall_left <= stall_left - 1;
        end else begin
            i_stall <= 0;
        end
    end

    initial begin
        mix = new();
        mix.clear();
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1;
        @(posedge i_clk);
        send_item(OP_GAIN, 0, 0, 17'd65536, 0, 0, 0, 0);
        send_item(OP_GAIN, 15, 15, 17'h1FFFF, 0, 0, 0, 0);
        send_item(OP_GAIN, 1, 3, 17'd0, 0, 0, 0, 0);
        send_item(OP_BLOCK, 0, 0, 0, 0, 0, 0, 0);
        send_item(OP_SAMPLE, 0, 0, 0, 0, 24'h7FFFFF, 0, 0);
        send_item(OP_SAMPLE, 15, 0, 0, 0, 24'h800000, 1, 0);
        send_item(OP_ROUTE, 2, 0, 0, 5'd16, 0, 0, 0);
        send_item(OP_ROUTE, 3, 0, 0, 5'd1, 0, 0, 0);
        send_item(OP_SAMPLE, 2, 0, 0, 0, 24'h7FFFFF, 0, 0);
        send_item(OP_SAMPLE, 3, 0, 0, 0, 24'h7FFFFF, 0, 0);
        send_item(OP_SAMPLE, 3, 0, 0, 0, 24'h7FFFFF, 1, 0);
        send_item(OP_BLOCK, 0, 0, 0, 0, 0, 0, 0);
        send_item(OP_ROUTE, 2, 0, 0, 5'd31, 0, 0, 0);
        send_item(OP_SAMPLE, 2, 0, 0, 0, 24'h123456, 1, 0);
        drain();
        apb_write(3'd0, 32'd0);
        apb_write(3'd4, 32'd0);
        send_item(OP_BLOCK, 0, 0, 0, 0, 0, 0, 0);
        send_item(OP_SAMPLE, 0, 0, 0, 0, 24'h400000, 1, 0);
        send_item(OP_SAMPLE, 3, 0, 0, 0, 24'h400000, 1, 0);
        drain();
        apb_write(3'd0, 32'h1FFFF);
        apb_write(3'd4, 32'd31);
        send_item(OP_BLOCK, 0, 0, 0, 0, 0, 0, 0);
        send_item(OP_SAMPLE, 15, 0, 0, 0, 24'h7FFFFF, 1, 0);
        drain();
        rx_random = 1;
        for (int ph = 0; ph < 4; ph++) begin
            case (ph)
                0: begin apb_write(3'd0, 32'd65536); apb_write(3'd4, 32'd16); end
                1: begin apb_write(3'd0, 32'd52429); apb_write(3'd4, 32'd1); end
                2: begin apb_write(3'd0, $urandom_range(0, 131071));
                         apb_write(3'd4, $urandom_range(2, 15)); end
                default: begin apb_write(3'd0, 32'd0); apb_write(3'd4, 32'd16); end
            endcase
            for (int i = 0; i < 110; i++) begin
                int gap;
                int k;
                gap = (i % 40 < 10) ? 0 : $urandom_range(0, 9);
                k = $urandom_range(0, 9);
                if (k < 3)
                    send_item(OP_GAIN, $urandom, $urandom,
                              $urandom_range(0, 3) == 0 ? $urandom : $urandom_range(0, 65536),
                              0, $urandom, $urandom, gap);
                else if (k == 3)
                    send_item(OP_ROUTE, $urandom, $urandom, $urandom,
                              $urandom_range(0, 2) == 0 ? $urandom : 5'd0, $urandom,
                              $urandom, gap);
                else if (k == 4)
                    send_item(OP_BLOCK, $urandom, $urandom, $urandom, $urandom,
                              $urandom, $urandom, gap);
                else
                    send_item(OP_SAMPLE, $urandom, $urandom, $urandom, $urandom,
                              rand_sample(), $urandom_range(0, 3) == 0, gap);
            end
            drain();
        end
        if (mix.errors == 0 && mix.pending.size() == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

    initial begin
        #8ms;
        $display("== FAIL ==");
        $finish;
    end
endmodule
